FILE: rtl/wag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wag_pkg
// Shared types and codes for the wire automaton grid block.
// ----------------------------------------------------------------------------
package wag_pkg;

  localparam int GRID_SIZE_DEF = 16;
  localparam int CELL_W        = 3;

  typedef logic [CELL_W-1:0] cell_t;

  localparam cell_t CODE_DEAD      = 3'd0;
  localparam cell_t CODE_HEAD      = 3'd1;
  localparam cell_t CODE_TAIL      = 3'd2;
  localparam cell_t CODE_TRACK     = 3'd3;
  localparam cell_t CODE_MOTOR_ONE = 3'd4;
  localparam cell_t CODE_MOTOR_TWO = 3'd5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic motor_one;
    logic motor_two;
  } motor_hit_t;

endpackage

FILE: rtl/wag_row_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wag_row_cell
// One grid row held in a register; takes its neighbor's row on each shift.
// ----------------------------------------------------------------------------
module wag_row_cell
  import wag_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    shift_en,
  input  cell_t [GRID_SIZE-1:0]   row_in,
  output cell_t [GRID_SIZE-1:0]   row_q
);

  cell_t [GRID_SIZE-1:0] row_r;
  cell_t [GRID_SIZE-1:0] row_nxt;

  always_comb begin
    row_nxt = shift_en ? row_in : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

FILE: rtl/wag_row_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wag_row_update
// Next-generation rule for one row, from the old rows above, at and below.
// ----------------------------------------------------------------------------
module wag_row_update
  import wag_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  cell_t [GRID_SIZE-1:0] row_prev,
  input  cell_t [GRID_SIZE-1:0] row_cur,
  input  cell_t [GRID_SIZE-1:0] row_next,
  output cell_t [GRID_SIZE-1:0] row_new,
  output motor_hit_t            hit
);

  // one dead column on either side stands in for the border
  cell_t [GRID_SIZE+1:0] pad_prev;
  cell_t [GRID_SIZE+1:0] pad_cur;
  cell_t [GRID_SIZE+1:0] pad_next;

  assign pad_prev = {CODE_DEAD, row_prev, CODE_DEAD};
  assign pad_cur  = {CODE_DEAD, row_cur, CODE_DEAD};
  assign pad_next = {CODE_DEAD, row_next, CODE_DEAD};

  always_comb begin
    logic head_nb;
    logic any_one;
    logic any_two;
    row_new       = row_cur;
    hit.motor_one = 1'b0;
    hit.motor_two = 1'b0;
    for (int j = 0; j < GRID_SIZE; j++) begin
      head_nb = 1'b0;
      any_one = 1'b0;
      any_two = 1'b0;
      // column j sits at j + 1 of the padded rows
      for (int k = 0; k < 3; k++) begin
        if (pad_prev[j+k] == CODE_HEAD) head_nb = 1'b1;
        if (pad_next[j+k] == CODE_HEAD) head_nb = 1'b1;
        if (k != 1 && pad_cur[j+k] == CODE_HEAD) head_nb = 1'b1;
        if (pad_prev[j+k] == CODE_MOTOR_ONE || pad_cur[j+k] == CODE_MOTOR_ONE ||
            pad_next[j+k] == CODE_MOTOR_ONE) any_one = 1'b1;
        if (pad_prev[j+k] == CODE_MOTOR_TWO || pad_cur[j+k] == CODE_MOTOR_TWO ||
            pad_next[j+k] == CODE_MOTOR_TWO) any_two = 1'b1;
      end
      case (row_cur[j])
        CODE_HEAD:  row_new[j] = CODE_TAIL;
        CODE_TAIL:  row_new[j] = CODE_TRACK;
        CODE_TRACK: row_new[j] = head_nb ? CODE_HEAD : CODE_TRACK;
        default:    row_new[j] = row_cur[j];
      endcase
      if (row_cur[j] == CODE_HEAD) begin
        hit.motor_one = hit.motor_one | any_one;
        hit.motor_two = hit.motor_two | any_two;
      end
    end
  end

endmodule

FILE: rtl/wire_automaton_grid_step.sv
`timescale 1ns / 1ps
// Sequencing: an accepted request rotates the whole row chain once in ST_RUN (one row
//   per cycle), then waits in ST_DONE for a free output slot, where the result is
//   registered; a new request is taken only back in ST_IDLE.
// Reset: synchronous, active-low rst_n clears all cells to dead, both motor flags
//   and the handshake state; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// wire_automaton_grid_step
// Six-state wire automaton on a GRID_SIZE x GRID_SIZE grid, stored as a ring of
// row cells that rotates once per request (write, read, step or clear).
// ----------------------------------------------------------------------------
module wire_automaton_grid_step
  import wag_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] pos_x, [15:8] pos_y, [18:16] cell_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] read_value, [3] motor_one, [4] motor_two
  output logic        out_tuser   // [0] bad_location
);

  localparam int ROW_W = $clog2(GRID_SIZE);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_SIZE - 1);

  // --------------------------------------------------------------------------
  // Control and latched request
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  cnt_r, cnt_nxt;
  logic              in_acc;
  logic              running;
  logic              last_row;

  op_t               op_r;
  logic [7:0]        x_r;
  logic [7:0]        y_r;
  cell_t             val_r;
  logic              inside_r;
  logic              inside_in;

  // Result side
  logic              out_valid_r, out_valid_nxt;
  cell_t             out_rv_r;
  logic              out_bad_r;
  logic              out_m1_r;
  logic              out_m2_r;
  logic              load_out;

  // Motor flags and per-step accumulation
  logic              m1_r, m2_r;
  motor_hit_t        acc_r;

  // Read capture
  cell_t             rd_r;

  // --------------------------------------------------------------------------
  // Row chain: cell 0 holds the row under work, processed rows enter at the top
  // --------------------------------------------------------------------------
  cell_t [GRID_SIZE-1:0] row_q [GRID_SIZE];
  cell_t [GRID_SIZE-1:0] row_cur;
  cell_t [GRID_SIZE-1:0] row_next;
  cell_t [GRID_SIZE-1:0] row_prev_r;
  cell_t [GRID_SIZE-1:0] row_stepped;
  cell_t [GRID_SIZE-1:0] row_written;
  cell_t [GRID_SIZE-1:0] row_out;
  motor_hit_t            hit;

  for (genvar k = 0; k < GRID_SIZE; k++) begin : g_chain
    cell_t [GRID_SIZE-1:0] link;
    if (k == GRID_SIZE - 1) begin : g_top
      assign link = row_out;
    end else begin : g_mid
      assign link = row_q[k+1];
    end
    wag_row_cell #(
      .GRID_SIZE (GRID_SIZE)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (running),
      .row_in   (link),
      .row_q    (row_q[k])
    );
  end

  assign running  = (state_r == ST_RUN);
  assign last_row = (cnt_r == LAST_ROW);
  assign row_cur  = row_q[0];
  // the row below the last one lies past the border: treat it as dead
  assign row_next = last_row ? '0 : row_q[1];

  wag_row_update #(
    .GRID_SIZE (GRID_SIZE)
  ) u_update (
    .row_prev (row_prev_r),
    .row_cur  (row_cur),
    .row_next (row_next),
    .row_new  (row_stepped),
    .hit      (hit)
  );

  // Write replaces one column of the addressed row
  always_comb begin
    for (int j = 0; j < GRID_SIZE; j++) begin
      row_written[j] = (ROW_W'(j) == y_r[ROW_W-1:0]) ? val_r : row_cur[j];
    end
  end

  // Select what re-enters the chain
  always_comb begin
    case (op_r)
      OP_WRITE: row_out = (inside_r && cnt_r == x_r[ROW_W-1:0]) ? row_written : row_cur;
      OP_STEP:  row_out = row_stepped;
      OP_CLEAR: row_out = '0;
      default:  row_out = row_cur;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake and sequencing
  // --------------------------------------------------------------------------
  assign inside_in = (in_tdata[7:0] < 8'(GRID_SIZE)) && (in_tdata[15:8] < 8'(GRID_SIZE));
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // hand the result over once the output slot is free
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_row) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      m1_r        <= 1'b0;
      m2_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      // a step replaces both motor flags; other operations keep them
      if (load_out && op_r == OP_STEP) begin
        m1_r <= acc_r.motor_one;
        m2_r <= acc_r.motor_two;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= op_t'(in_tuser);
      x_r        <= in_tdata[7:0];
      y_r        <= in_tdata[15:8];
      val_r      <= in_tdata[18:16];
      inside_r   <= inside_in;
      row_prev_r <= '0;
      acc_r      <= '0;
      rd_r       <= CODE_DEAD;
    end else if (running) begin
      // hold the old row for the next row's upper neighbors
      row_prev_r      <= row_cur;
      acc_r.motor_one <= acc_r.motor_one | hit.motor_one;
      acc_r.motor_two <= acc_r.motor_two | hit.motor_two;
      if (op_r == OP_READ && inside_r && cnt_r == x_r[ROW_W-1:0]) begin
        rd_r <= row_cur[y_r[ROW_W-1:0]];
      end
    end
    if (load_out) begin
      out_rv_r  <= rd_r;
      out_bad_r <= (op_r == OP_WRITE || op_r == OP_READ) && !inside_r;
      out_m1_r  <= (op_r == OP_STEP) ? acc_r.motor_one : m1_r;
      out_m2_r  <= (op_r == OP_STEP) ? acc_r.motor_two : m2_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_m2_r, out_m1_r, out_rv_r};
  assign out_tuser  = out_bad_r;

endmodule

FILE: rtl/wag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wag_checker
// Port-level checks on the wire automaton grid block, bound to the top level.
// ----------------------------------------------------------------------------
module wag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request in flight: ready drops right after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // a flagged location never returns cell data
  a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2:0] == 3'd0)
    else $error("read data with bad location");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] == 3'd0)
    else $error("nonzero padding in result");

endmodule

bind wire_automaton_grid_step wag_checker u_wag_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/wire_automaton_grid_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wire_automaton_grid_step_tb
// Self-checking bench for the wire automaton grid. A local shadow of the grid
// and motor flags predicts every result; results are matched in order, field
// by field, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module wire_automaton_grid_step_tb;
  import wag_pkg::*;

  localparam int GRID           = GRID_SIZE_DEF;
  localparam int LONG_HOLD      = 400;   // receiver hold-off that fills the block
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake on either side

  // Codes the block stores but never evolves
  localparam cell_t CODE_SPARE_SIX   = 3'd6;
  localparam cell_t CODE_SPARE_SEVEN = 3'd7;

  typedef struct {
    cell_t read_value;
    logic  bad_location;
    logic  motor_one;
    logic  motor_two;
  } grid_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;    // [7:0] pos_x, [15:8] pos_y, [18:16] cell_value
  logic [1:0]  in_tuser   = '0;    // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [2:0] read_value, [3] motor_one, [4] motor_two
  logic        out_tuser;          // [0] bad_location

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wire_automaton_grid_step #(
    .GRID_SIZE(GRID)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // --------------------------------------------------------------------------
  // Shadow grid and motor flags, updated once per accepted request
  // --------------------------------------------------------------------------
  cell_t        shadow_grid [GRID][GRID];   // indexed [pos_x][pos_y]
  logic         shadow_motor_one;
  logic         shadow_motor_two;
  grid_result_t pending_results [$];        // predicted results, oldest first

  int unsigned  mismatches    = 0;
  int unsigned  requests_sent = 0;
  int unsigned  burst_left    = 0;
  bit           gaps_enabled  = 1'b1;
  bit           long_hold_req = 1'b0;

  function automatic void wipe_shadow_grid();
    foreach (shadow_grid[x, y]) shadow_grid[x][y] = CODE_DEAD;
  endfunction

  // Cells off the edge of the grid read as dead
  function automatic cell_t cell_or_dead(int x, int y);
    if (x < 0 || y < 0 || x >= GRID || y >= GRID) return CODE_DEAD;
    return shadow_grid[x][y];
  endfunction

  // One generation: every cell computed from the old grid, then swapped in
  function automatic void advance_generation();
    cell_t next_cells [GRID][GRID];
    cell_t here;
    cell_t nbr;
    shadow_motor_one = 1'b0;
    shadow_motor_two = 1'b0;
    for (int x = 0; x < GRID; x++) begin
      for (int y = 0; y < GRID; y++) begin
        here = shadow_grid[x][y];
        next_cells[x][y] = here;
        if (here == CODE_HEAD) begin
          next_cells[x][y] = CODE_TAIL;
          // A head raises the flag of any motor kind in its neighborhood
          for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
              nbr = cell_or_dead(x + dx, y + dy);
              if (nbr == CODE_MOTOR_ONE) shadow_motor_one = 1'b1;
              if (nbr == CODE_MOTOR_TWO) shadow_motor_two = 1'b1;
            end
          end
        end else if (here == CODE_TAIL) begin
          next_cells[x][y] = CODE_TRACK;
        end else if (here == CODE_TRACK) begin
          for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
              if ((dx != 0 || dy != 0) && cell_or_dead(x + dx, y + dy) == CODE_HEAD)
                next_cells[x][y] = CODE_HEAD;
            end
          end
        end
      end
    end
    shadow_grid = next_cells;
  endfunction

  // Apply one request to the shadow state and return the result it yields
  function automatic grid_result_t apply_request(op_t op, logic [7:0] px, logic [7:0] py,
                                                 cell_t val);
    grid_result_t res;
    logic         on_grid;
    res = '{read_value: CODE_DEAD, bad_location: 1'b0, motor_one: 1'b0, motor_two: 1'b0};
    on_grid = (px < GRID) && (py < GRID);
    case (op)
      OP_WRITE: begin
        if (on_grid) shadow_grid[px][py] = val;
        else res.bad_location = 1'b1;
      end
      OP_READ: begin
        if (on_grid) res.read_value = shadow_grid[px][py];
        else res.bad_location = 1'b1;
      end
      OP_STEP:  advance_generation();
      OP_CLEAR: wipe_shadow_grid();   // motor flags survive a clear
      default: begin
      end
    endcase
    res.motor_one = shadow_motor_one;
    res.motor_two = shadow_motor_two;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one request, wait for the handshake, predict its result.
  // Requests go out in bursts; a gap may open before each new burst.
  // --------------------------------------------------------------------------
  task automatic send_request(op_t op, int px, int py, cell_t val);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (gaps_enabled && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, val, 8'(py), 8'(px)};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_request(op, 8'(px), 8'(py), val));
    requests_sent++;
    burst_left--;
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly wire material, with a few of every other code
  function automatic cell_t pick_cell();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return CODE_TRACK;
    if (roll < 45) return CODE_HEAD;
    if (roll < 55) return CODE_TAIL;
    if (roll < 63) return CODE_MOTOR_ONE;
    if (roll < 71) return CODE_MOTOR_TWO;
    if (roll < 93) return CODE_DEAD;
    if (roll < 97) return CODE_SPARE_SIX;
    return CODE_SPARE_SEVEN;
  endfunction

  // Write a cell on a lane (row or column) of a wire
  task automatic write_on_lane(bit vertical, int lane, int pos, cell_t val);
    if (vertical) send_request(OP_WRITE, pos, lane, val);
    else send_request(OP_WRITE, lane, pos, val);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corners, borders, bad coordinates, spare codes, motors and clear
  task automatic test_directed_corners();
    send_request(OP_READ,  0,        0,        CODE_DEAD);          // freshly reset grid
    send_request(OP_WRITE, 0,        0,        CODE_HEAD);
    send_request(OP_WRITE, 1,        1,        CODE_TRACK);
    send_request(OP_WRITE, 0,        1,        CODE_MOTOR_TWO);
    send_request(OP_WRITE, GRID - 1, GRID - 1, CODE_TRACK);
    send_request(OP_WRITE, GRID - 1, GRID - 2, CODE_HEAD);
    send_request(OP_WRITE, GRID - 2, GRID - 1, CODE_MOTOR_ONE);
    // Off-grid writes: flagged, grid untouched
    send_request(OP_WRITE, GRID,     0,        CODE_SPARE_SEVEN);
    send_request(OP_WRITE, 0,        255,      CODE_MOTOR_TWO);
    send_request(OP_WRITE, 255,      255,      CODE_TAIL);
    // Off-grid reads: flagged, value zero
    send_request(OP_READ,  GRID,     3,        CODE_SPARE_SEVEN);
    send_request(OP_READ,  3,        GRID,     CODE_DEAD);
    // Spare codes store, read back and stay inert
    send_request(OP_WRITE, 7,        7,        CODE_SPARE_SIX);
    send_request(OP_WRITE, 8,        8,        CODE_SPARE_SEVEN);
    send_request(OP_READ,  7,        7,        CODE_DEAD);
    send_request(OP_READ,  8,        8,        CODE_DEAD);
    // Step with heads next to both motor kinds at opposite corners
    send_request(OP_STEP,  200,      31,       CODE_SPARE_SEVEN);
    send_request(OP_READ,  1,        1,        CODE_DEAD);
    send_request(OP_READ,  8,        8,        CODE_DEAD);
    send_request(OP_READ,  GRID - 1, GRID - 1, CODE_DEAD);
    // Clear keeps the motor flags; the next step on an empty grid drops them
    send_request(OP_CLEAR, 255,      255,      CODE_SPARE_SEVEN);
    send_request(OP_READ,  0,        0,        CODE_DEAD);
    send_request(OP_STEP,  0,        0,        CODE_DEAD);
  endtask

  // Hold the result side off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    gaps_enabled = 1'b0;
    long_hold_req = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 1)) begin
        send_request(OP_WRITE, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                     pick_cell());
      end else begin
        send_request(OP_READ, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                     CODE_DEAD);
      end
    end
    gaps_enabled = 1'b1;
  endtask

  // Pause the sender until the block has returned everything
  task automatic test_pause_until_empty();
    repeat (6) send_request(op_t'($urandom_range(0, 2)), $urandom_range(0, GRID - 1),
                            $urandom_range(0, GRID - 1), pick_cell());
    drain_results();
    repeat (6) send_request(op_t'($urandom_range(0, 2)), $urandom_range(0, GRID - 1),
                            $urandom_range(0, GRID - 1), pick_cell());
  endtask

  // Lay a wire with a head at one end, maybe a motor and a branch, then run
  // pulses along it with reads and the odd stray request in between
  task automatic test_wire_pulses(int unsigned upto);
    bit vertical;
    int lane;
    int len;
    int start;
    int probe;
    while (requests_sent < upto) begin
      vertical = $urandom_range(0, 1);
      lane     = $urandom_range(0, GRID - 1);
      len      = $urandom_range(3, GRID);
      start    = $urandom_range(0, GRID - len);
      if ($urandom_range(0, 3) == 0)
        send_request(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                     3'($urandom_range(0, 7)));
      for (int i = 0; i < len; i++)
        write_on_lane(vertical, lane, start + i, (i == 0) ? CODE_HEAD : CODE_TRACK);
      if ($urandom_range(0, 1))
        write_on_lane(vertical, (lane == 0) ? 1 : lane - 1, start + len - 1,
                      $urandom_range(0, 1) ? CODE_MOTOR_ONE : CODE_MOTOR_TWO);
      if ($urandom_range(0, 2) == 0)
        write_on_lane(vertical, (lane < GRID - 1) ? lane + 1 : lane - 1,
                      start + $urandom_range(0, len - 1), CODE_TRACK);
      repeat (len + 2) begin
        send_request(OP_STEP, $urandom_range(0, 255), $urandom_range(0, 255),
                     3'($urandom_range(0, 7)));
        if ($urandom_range(0, 1)) begin
          probe = start + $urandom_range(0, len - 1);
          if (vertical) send_request(OP_READ, probe, lane, CODE_DEAD);
          else send_request(OP_READ, lane, probe, CODE_DEAD);
        end
        if ($urandom_range(0, 7) == 0)
          send_request(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                       $urandom_range(0, 255), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  // Weighted mix of all operations, including off-grid coordinates
  task automatic test_random_mix(int unsigned upto);
    int unsigned roll;
    int          px;
    int          py;
    while (requests_sent < upto) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        px = $urandom_range(0, 255);
        py = $urandom_range(0, 255);
      end else begin
        px = $urandom_range(0, GRID - 1);
        py = $urandom_range(0, GRID - 1);
      end
      if (roll < 45) send_request(OP_WRITE, px, py, pick_cell());
      else if (roll < 75) send_request(OP_READ, px, py, 3'($urandom_range(0, 7)));
      else if (roll < 96) send_request(OP_STEP, px, py, 3'($urandom_range(0, 7)));
      else send_request(OP_CLEAR, px, py, 3'($urandom_range(0, 7)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall on a rotating pattern that changes every so often, and
  // hold off entirely while a long hold-off is counting down
  // --------------------------------------------------------------------------
  logic [15:0] stall_pattern = 16'hffff;
  int unsigned pattern_age   = 0;
  int unsigned hold_count    = 0;

  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_count    = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_tready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(32, 128);
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hffff;                                     // no stalls
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom | $urandom);                     // mostly ready
          default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;    // mostly stalled
        endcase
      end
      pattern_age--;
      out_tready    <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: match each accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  grid_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: tdata 0x%02h tuser %0b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[2:0] !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_tdata[2:0]);
          mismatches++;
        end
        if (out_tuser !== want.bad_location) begin
          $error("bad_location: expected %0b, got %0b", want.bad_location, out_tuser);
          mismatches++;
        end
        if (out_tdata[3] !== want.motor_one) begin
          $error("motor_one: expected %0b, got %0b", want.motor_one, out_tdata[3]);
          mismatches++;
        end
        if (out_tdata[4] !== want.motor_two) begin
          $error("motor_two: expected %0b, got %0b", want.motor_two, out_tdata[4]);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither side completes a handshake for too long
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    wipe_shadow_grid();
    shadow_motor_one = 1'b0;
    shadow_motor_two = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_output_backpressure();
    test_pause_until_empty();
    test_wire_pulses(requests_sent + 320);
    test_random_mix(requests_sent + 360);

    // Let the last results come back, then idle a while before the final check
    drain_results();
    repeat (GRID + 4) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
